// ----- src/nwe_pkg.sv -----
// nwe_pkg: shared widths, codes, state and command types for the net wirelength estimator
// no dependencies; imported by nwe_dp, nwe_ctrl and the top level
`timescale 1ns / 1ps
`default_nettype none

package nwe_pkg;

    // fixed field widths
    localparam int PIN_W   = 31;
    localparam int LEN_W   = 42;
    localparam int TOT_W   = 63;
    localparam int MODE_W  = 2;

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ESTIMATE_MODE = REG_IDX_W'(0);

    // parameter defaults
    localparam int DEF_MAX_PINS   = 1024;
    localparam int DEF_COORD_BITS = 31;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    // estimate modes
    localparam logic [MODE_W-1:0] MODE_HPWL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HTRUNK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VTRUNK = 2'd2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_EVAL,
        S_DIV,
        S_WALK,
        S_FIN,
        S_TOT
    } t_state;

    typedef struct packed {
        logic pin_load;
        logic div_start;
        logic walk_start;
        logic walk_step;
        logic fin;
        logic fin_use_dev;
        logic tot;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic walk_done;
        logic over;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- src/nwe_ram.sv -----
// nwe_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module nwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/nwe_div.sv -----
// nwe_div: restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module nwe_div #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic      [DIVIDEND_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [DIVIDEND_W-1:0] r_q;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    rem_sh;
    logic                  ge;
    logic [DIVISOR_W:0]    rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_q[DIVIDEND_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where the dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIVIDEND_W-2:0], ge};
            r_rem <= rem_sub[DIVISOR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ----- src/nwe_dp.sv -----
// nwe_dp: per-net accumulators, coordinate store, mean divider, deviation walk and totals
// depends on nwe_pkg, nwe_ram and nwe_div
`timescale 1ns / 1ps
`default_nettype none

module nwe_dp #(
    parameter int MAX_PINS   = nwe_pkg::DEF_MAX_PINS,
    parameter int COORD_BITS = nwe_pkg::DEF_COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [nwe_pkg::PIN_W-1:0]    i_pin_x,
    input  wire logic [nwe_pkg::PIN_W-1:0]    i_pin_y,
    input  wire logic                         i_clear_total,
    input  wire logic [nwe_pkg::MODE_W-1:0]   i_mode,
    input  wire nwe_pkg::t_dp_cmd             i_cmd,
    output nwe_pkg::t_dp_sts                  o_sts,
    output logic      [nwe_pkg::LEN_W-1:0]    o_net_length,
    output logic      [nwe_pkg::TOT_W-1:0]    o_total_length,
    output logic                              o_too_many_pins
);

    import nwe_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int CNT_W = $clog2(MAX_PINS + 2);
    localparam int AW    = $clog2(MAX_PINS);
    localparam int SUM_W = CB + $clog2(MAX_PINS + 1);

    logic [CB-1:0]    x_c;
    logic [CB-1:0]    y_c;
    logic [CB-1:0]    tc;
    logic [CB-1:0]    sc;

    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_sum;
    logic [CB-1:0]    r_smax;
    logic [CB-1:0]    r_smin;
    logic [CB-1:0]    r_tmax;
    logic [CB-1:0]    r_tmin;
    logic [TOT_W-1:0] r_total;

    logic [CNT_W-1:0] r_walk_idx;
    logic             r_rd_pend;
    logic [SUM_W-1:0] r_dev;

    logic [LEN_W-1:0] r_len;
    logic             r_over;
    logic [LEN_W-1:0] r_out_len;
    logic [TOT_W-1:0] r_out_total;
    logic             r_out_over;

    logic             below_cap;
    logic             over;
    logic             walk_issue;
    logic [CB-1:0]    rd_coord;
    logic             div_done;
    logic [SUM_W-1:0] div_quot;
    logic [CB-1:0]    mean;
    logic [CB-1:0]    abs_dev;
    logic [CB-1:0]    span;
    logic [CB-1:0]    tdiff;
    logic [63:0]      len_raw;
    logic [LEN_W-1:0] len_sat;
    logic [63:0]      tot_sum;
    logic [TOT_W-1:0] n_total;

    assign x_c = i_pin_x[CB-1:0];
    assign y_c = i_pin_y[CB-1:0];
    assign tc  = (i_mode == MODE_VTRUNK) ? y_c : x_c;
    assign sc  = (i_mode == MODE_VTRUNK) ? x_c : y_c;

    assign below_cap  = r_cnt < CNT_W'(MAX_PINS);
    assign over       = r_cnt > CNT_W'(MAX_PINS);
    assign walk_issue = i_cmd.walk_step && (r_walk_idx < r_cnt);

    nwe_ram #(
        .WIDTH (CB),
        .DEPTH (MAX_PINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pin_load && below_cap),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (tc),
        .i_raddr (r_walk_idx[AW-1:0]),
        .o_rdata (rd_coord)
    );

    nwe_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // mean never exceeds the largest coordinate, so the low bits hold it
    assign mean    = div_quot[CB-1:0];
    assign abs_dev = (rd_coord >= mean) ? (rd_coord - mean) : (mean - rd_coord);

    always_comb begin
        span    = r_smax - r_smin;
        tdiff   = r_tmax - r_tmin;
        len_raw = i_cmd.fin_use_dev ? (64'(r_dev) + 64'(span))
                                    : (64'(tdiff) + 64'(span));
        len_sat = (len_raw > 64'(LEN_MAX)) ? LEN_MAX : len_raw[LEN_W-1:0];
        tot_sum = 64'(r_total) + 64'(r_len);
        n_total = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
    end

    // per-net accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.tot) begin
            r_cnt  <= '0;
            r_sum  <= '0;
            r_smax <= '0;
            r_smin <= '1;
            r_tmax <= '0;
            r_tmin <= '1;
        end else if (i_cmd.pin_load) begin
            if (below_cap) begin
                r_sum <= r_sum + SUM_W'(tc);
            end
            if (r_cnt <= CNT_W'(MAX_PINS)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (tc > r_tmax) r_tmax <= tc;
            if (tc < r_tmin) r_tmin <= tc;
            if (sc > r_smax) r_smax <= sc;
            if (sc < r_smin) r_smin <= sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.pin_load && i_clear_total) begin
            r_total <= '0;
        end else if (i_cmd.tot) begin
            r_total <= n_total;
        end
    end

    // deviation walk over the stored trunk coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.walk_start) begin
            r_walk_idx <= '0;
            r_rd_pend  <= 1'b0;
        end else if (i_cmd.walk_step) begin
            if (walk_issue) begin
                r_walk_idx <= r_walk_idx + CNT_W'(1);
            end
            r_rd_pend <= walk_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_dev <= '0;
        end else if (r_rd_pend) begin
            r_dev <= r_dev + SUM_W'(abs_dev);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_len  <= over ? '0 : len_sat;
            r_over <= over;
        end
        if (i_cmd.tot) begin
            r_out_len   <= r_len;
            r_out_total <= n_total;
            r_out_over  <= r_over;
        end
    end

    assign o_sts.div_done  = div_done;
    assign o_sts.walk_done = (r_walk_idx == r_cnt) && !r_rd_pend;
    assign o_sts.over      = over;

    assign o_net_length    = r_out_len;
    assign o_total_length  = r_out_total;
    assign o_too_many_pins = r_out_over;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_PINS + 1))
        else $error("pin count beyond capacity plus one");

    a_mean_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (div_quot[SUM_W-1:CB] == '0))
        else $error("mean wider than a coordinate");

    a_walk_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> !over)
        else $error("store walk on an oversized net");
`endif

endmodule

`default_nettype wire

// ----- src/nwe_ctrl.sv -----
// nwe_ctrl: sequencer for pin loading, mean division, deviation walk and result output
// depends on nwe_pkg
`timescale 1ns / 1ps
`default_nettype none

module nwe_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_last_pin,
    input  wire logic                       i_out_stall,
    input  wire logic [nwe_pkg::MODE_W-1:0] i_mode,
    input  wire nwe_pkg::t_dp_sts           i_sts,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output nwe_pkg::t_dp_cmd                o_cmd
);

    import nwe_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_use_dev;
    logic    n_use_dev;
    logic    r_out_vld;
    logic    in_stall;
    logic    accept;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_use_dev <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_use_dev <= n_use_dev;
            if (r_state == S_TOT) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_use_dev = r_use_dev;
        cmd       = '0;
        in_stall  = 1'b1;
        accept    = 1'b0;
        case (r_state)
            S_LOAD: begin
                // a closing word waits while the previous result is still held
                in_stall     = i_last_pin && r_out_vld && i_out_stall;
                accept       = i_in_valid && !in_stall;
                cmd.pin_load = accept;
                if (accept && i_last_pin) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_sts.over && (i_mode inside {MODE_HTRUNK, MODE_VTRUNK})) begin
                    cmd.div_start = 1'b1;
                    n_use_dev     = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    n_use_dev = 1'b0;
                    n_state   = S_FIN;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    cmd.walk_start = 1'b1;
                    n_state        = S_WALK;
                end
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                cmd.fin         = 1'b1;
                cmd.fin_use_dev = r_use_dev;
                n_state         = S_TOT;
            end
            S_TOT: begin
                cmd.tot = 1'b1;
                n_state = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_in_stall  = in_stall;
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;

`ifndef ASSERT_OFF
    a_last_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_pin) |=> (r_state == S_EVAL))
        else $error("closing word did not start evaluation");

    a_out_from_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_TOT))
        else $error("result raised outside the total step");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> o_in_stall)
        else $error("input taken while a net is in progress");
`endif

endmodule

`default_nettype wire

// ----- src/net_wirelength_estimator_top.sv -----
// channel  | direction | handshake                     | payload
// pin in   | in        | i_in_valid / o_in_stall       | i_pin_x, i_pin_y, i_last_pin, i_clear_total
// result   | out       | o_out_valid / i_out_stall     | o_net_length, o_total_length, o_too_many_pins
// config   | in        | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// pins load at one per cycle while the sequencer is in its load state; a net that closes in
// half perimeter mode, or with too many pins, passes the eval, fin and tot states to its result
// trunk modes add the mean divider, one quotient bit per cycle over the sum width
// (COORD_BITS + clog2(MAX_PINS+1) bits), then a walk of the coordinate store
// at one read per cycle through its single read port
// reset is synchronous and active low; the store needs no clearing pass
// a closing pin is held off while the previous result waits on a stalled output
//
// net_wirelength_estimator_top: wirelength estimator top level with the mode register
// depends on nwe_pkg, nwe_ctrl, nwe_dp (and through it nwe_ram, nwe_div)
`timescale 1ns / 1ps
`default_nettype none

module net_wirelength_estimator_top #(
    parameter int MAX_PINS   = nwe_pkg::DEF_MAX_PINS,
    parameter int COORD_BITS = nwe_pkg::DEF_COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [nwe_pkg::PIN_W-1:0]    i_pin_x,
    input  wire logic [nwe_pkg::PIN_W-1:0]    i_pin_y,
    input  wire logic                         i_last_pin,
    input  wire logic                         i_clear_total,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [nwe_pkg::LEN_W-1:0]    o_net_length,
    output logic      [nwe_pkg::TOT_W-1:0]    o_total_length,
    output logic                              o_too_many_pins,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [nwe_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [nwe_pkg::PDATA_W-1:0]  pwdata,
    output logic      [nwe_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    import nwe_pkg::*;

    logic [MODE_W-1:0]    r_mode;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    t_dp_cmd              cmd;
    t_dp_sts              sts;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HPWL;
        end else if (cfg_wr && (reg_idx == REG_ESTIMATE_MODE)) begin
            r_mode <= pwdata[MODE_W-1:0];
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ESTIMATE_MODE: prdata = {(PDATA_W - MODE_W)'(0), r_mode};
            default:           prdata = '0;
        endcase
    end

    nwe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_pin  (i_last_pin),
        .i_out_stall (i_out_stall),
        .i_mode      (r_mode),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    nwe_dp #(
        .MAX_PINS   (MAX_PINS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pin_x         (i_pin_x),
        .i_pin_y         (i_pin_y),
        .i_clear_total   (i_clear_total),
        .i_mode          (r_mode),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_net_length    (o_net_length),
        .o_total_length  (o_total_length),
        .o_too_many_pins (o_too_many_pins)
    );

endmodule

`default_nettype wire
